@@ hdl/cfe_pkg.sv @@
// Shared types, constants and functions of the command frame encoder.
package cfe_pkg;

  // Opcode of a command.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Frame constants.
  localparam logic [7:0] FRAME_SYNC     = 8'h1E;
  localparam logic [7:0] FRAME_WR_FLAG  = 8'h80;
  localparam logic [7:0] FRAME_POLY     = 8'h2F;
  localparam logic [7:0] FRAME_CRC_INIT = 8'h00;

  // Number of payload bytes ahead of the CRC in the longest frame.
  localparam int unsigned BODY_BYTES = 5;
  localparam int unsigned IDX_W      = 3;

  // Position of the CRC byte for each frame kind.
  localparam logic [IDX_W-1:0] READ_LAST_IDX  = 3'd3;
  localparam logic [IDX_W-1:0] WRITE_LAST_IDX = 3'd5;

  // A classified command: frame body bytes and the index of the CRC byte.
  typedef struct packed {
    logic [BODY_BYTES-1:0][7:0] body;
    logic [IDX_W-1:0]           last_idx;
  } frame_t;

  // One byte of CRC-8, polynomial 0x2F, MSB first.
  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ FRAME_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Bit reversal of one byte.
  function automatic logic [7:0] reverse8(logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

endpackage

@@ hdl/cfe_if.sv @@
// Channel interfaces for commands in and frame bytes out.
interface cfe_cmd_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [6:0]  node_id;
  logic [7:0]  reg_addr;
  logic [15:0] write_data;

  modport source (output valid, opcode, node_id, reg_addr, write_data, input ready);
  modport sink   (input valid, opcode, node_id, reg_addr, write_data, output ready);
endinterface

interface cfe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;

  modport source (output valid, tx_byte, last_byte, input ready);
  modport sink   (input valid, tx_byte, last_byte, output ready);
endinterface

@@ hdl/cfe_front.sv @@
// Front end: accepts commands and classifies them into frame descriptors.
module cfe_front (
  input  logic            clk,
  input  logic            rst,
  cfe_cmd_if.sink         cmd,
  output logic            fr_valid,
  input  logic            fr_ready,
  output cfe_pkg::frame_t fr
);

  logic            fr_valid_next;
  cfe_pkg::frame_t fr_next;
  logic            take;

  // A new command enters when the stage is empty or drains this cycle.
  assign cmd.ready = !fr_valid || fr_ready;
  assign take      = cmd.valid && cmd.ready;

  // Build the frame body and pick the frame length from the opcode.
  always_comb begin
    fr_next         = fr;
    fr_next.body[0] = cfe_pkg::FRAME_SYNC;
    fr_next.body[2] = cmd.reg_addr;
    if (cmd.opcode == cfe_pkg::OP_WRITE) begin
      fr_next.body[1]  = {1'b0, cmd.node_id} | cfe_pkg::FRAME_WR_FLAG;
      fr_next.body[3]  = cmd.write_data[15:8];
      fr_next.body[4]  = cmd.write_data[7:0];
      fr_next.last_idx = cfe_pkg::WRITE_LAST_IDX;
    end else begin
      fr_next.body[1]  = {1'b0, cmd.node_id};
      fr_next.body[3]  = 8'h00;
      fr_next.body[4]  = 8'h00;
      fr_next.last_idx = cfe_pkg::READ_LAST_IDX;
    end
  end

  always_comb begin
    fr_valid_next = fr_valid;
    if (take) begin
      fr_valid_next = 1'b1;
    end else if (fr_ready) begin
      fr_valid_next = 1'b0;
    end
  end

  // Stage register; the descriptor itself needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else begin
      fr_valid <= fr_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fr <= fr_next;
    end
  end

endmodule

@@ hdl/cfe_queue.sv @@
// Short queue of frame descriptors between the front and back ends.
module cfe_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  cfe_pkg::frame_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output cfe_pkg::frame_t pop_data
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cfe_pkg::frame_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers wrap at the depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/cfe_back.sv @@
// Back end: serializes one frame a byte per cycle while the receiver is ready and appends the CRC.
module cfe_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            fr_valid,
  output logic            fr_ready,
  input  cfe_pkg::frame_t fr,
  cfe_byte_if.source      tx
);

  cfe_pkg::frame_t           cur;
  logic                      busy;
  logic [cfe_pkg::IDX_W-1:0] idx;
  logic [7:0]                crc;
  logic                      out_valid;
  logic [7:0]                out_byte;
  logic                      out_last;

  logic                      busy_next;
  logic [cfe_pkg::IDX_W-1:0] idx_next;
  logic [7:0]                crc_next;
  logic                      out_valid_next;
  logic [7:0]                out_byte_next;
  logic                      out_last_next;
  logic                      advance;
  logic                      at_crc;
  logic                      load;
  logic [7:0]                cur_byte;

  assign tx.valid     = out_valid;
  assign tx.tx_byte   = out_byte;
  assign tx.last_byte = out_last;

  // A byte moves out when the output register is free or being emptied.
  assign advance  = busy && (!out_valid || tx.ready);
  assign at_crc   = (idx == cur.last_idx);
  assign cur_byte = at_crc ? crc : cur.body[idx];

  // Next frame is taken when idle or when the current one sends its CRC.
  assign fr_ready = !busy || (advance && at_crc);
  assign load     = fr_valid && fr_ready;

  always_comb begin
    busy_next      = busy;
    idx_next       = idx;
    crc_next       = crc;
    out_valid_next = out_valid;
    out_byte_next  = out_byte;
    out_last_next  = out_last;

    // Output register drains when taken.
    if (tx.ready) begin
      out_valid_next = 1'b0;
    end

    // Emit the current byte and fold it into the running CRC.
    if (advance) begin
      out_valid_next = 1'b1;
      out_byte_next  = cfe_pkg::reverse8(cur_byte);
      out_last_next  = at_crc;
      crc_next       = cfe_pkg::crc8_byte(crc, cur_byte);
      idx_next       = idx + 1'b1;
      if (at_crc) begin
        busy_next = 1'b0;
      end
    end

    // Start the next frame from the first byte with a fresh CRC.
    if (load) begin
      busy_next = 1'b1;
      idx_next  = '0;
      crc_next  = cfe_pkg::FRAME_CRC_INIT;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      busy      <= busy_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload state.
  always_ff @(posedge clk) begin
    idx      <= idx_next;
    crc      <= crc_next;
    out_byte <= out_byte_next;
    out_last <= out_last_next;
    if (load) begin
      cur <= fr;
    end
  end

endmodule

@@ hdl/crc_framed_register_command_encoder_unit.sv @@
// Top level of the register command frame encoder.
// A command passes the front stage, the queue and the back end's output register before its first byte appears.
// A write frame has six bytes and a read frame four, sent one byte per cycle while the
// receiver is ready; frames follow without a gap when the next one is already queued.
// Commands queue ahead of the serializer, so new ones are taken while a frame is sent.
// Synchronous reset empties the front stage, the queue and the output register.
module crc_framed_register_command_encoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  cfe_cmd_if.sink    cmd,
  cfe_byte_if.source tx
);

  logic            f_valid;
  logic            f_ready;
  cfe_pkg::frame_t f_frame;
  logic            b_valid;
  logic            b_ready;
  cfe_pkg::frame_t b_frame;

  // Command intake and classification.
  cfe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .fr_valid (f_valid),
    .fr_ready (f_ready),
    .fr       (f_frame)
  );

  // Decoupling queue.
  cfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_frame),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_frame)
  );

  // Byte serializer with CRC.
  cfe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .fr_valid (b_valid),
    .fr_ready (b_ready),
    .fr       (b_frame),
    .tx       (tx)
  );

endmodule

@@ dv/tb_crc_framed_register_command_encoder_unit.sv @@
// Self-checking testbench for the register command frame encoder: random and directed commands.
module tb_crc_framed_register_command_encoder_unit;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned RANDOM_ITEMS   = 68;
  localparam int unsigned BURST_ITEMS    = 30;

  // One register command as offered on the command channel.
  typedef struct {
    logic        opcode;
    logic [6:0]  node_id;
    logic [7:0]  reg_addr;
    logic [15:0] write_data;
  } command_t;

  // One frame byte as it should leave the block.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } frame_byte_t;

  logic clk = 1'b0;
  logic rst;

  cfe_cmd_if  cmd_ch ();
  cfe_byte_if tx_ch ();

  crc_framed_register_command_encoder_unit dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .tx  (tx_ch)
  );

  frame_byte_t expected_frame_bytes [$];
  int          error_count = 0;
  int          idle_cycles = 0;
  bit          no_idle     = 1'b0;

  always #5 clk = ~clk;

  // CRC-8 update, one bit at a time, MSB first.
  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] value);
    logic feedback;
    for (int i = 7; i >= 0; i--) begin
      feedback = crc[7] ^ value[i];
      crc = {crc[6:0], 1'b0} ^ (feedback ? cfe_pkg::FRAME_POLY : 8'h00);
    end
    return crc;
  endfunction

  // Swaps bit 0 with bit 7, bit 1 with bit 6, and so on.
  function automatic logic [7:0] mirror_byte(logic [7:0] v);
    logic [7:0] m;
    for (int i = 0; i < 8; i++) begin
      m[i] = v[7-i];
    end
    return m;
  endfunction

  // Builds the frame of one command and queues its bytes as they should be sent.
  function automatic void queue_frame_bytes(command_t c);
    logic [7:0]  frame [6];
    logic [7:0]  crc;
    int          crc_idx;
    frame_byte_t entry;
    frame[0] = cfe_pkg::FRAME_SYNC;
    frame[1] = {1'b0, c.node_id};
    frame[2] = c.reg_addr;
    if (c.opcode == cfe_pkg::OP_WRITE) begin
      frame[1] = frame[1] | cfe_pkg::FRAME_WR_FLAG;
      frame[3] = c.write_data[15:8];
      frame[4] = c.write_data[7:0];
      crc_idx = 5;
    end else begin
      crc_idx = 3;
    end
    crc = cfe_pkg::FRAME_CRC_INIT;
    for (int k = 0; k < crc_idx; k++) begin
      crc = crc8_update(crc, frame[k]);
    end
    frame[crc_idx] = crc;
    for (int k = 0; k <= crc_idx; k++) begin
      entry.tx_byte   = mirror_byte(frame[k]);
      entry.last_byte = (k == crc_idx);
      expected_frame_bytes.push_back(entry);
    end
  endfunction

  // Every accepted command adds its frame to the expected bytes.
  always @(posedge clk) begin : track_commands
    command_t c;
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      c.opcode     = cmd_ch.opcode;
      c.node_id    = cmd_ch.node_id;
      c.reg_addr   = cmd_ch.reg_addr;
      c.write_data = cmd_ch.write_data;
      queue_frame_bytes(c);
    end
  end

  // Every accepted frame byte is compared with the oldest expected one.
  always @(posedge clk) begin : check_frame_bytes
    frame_byte_t want;
    if (!rst && tx_ch.valid && tx_ch.ready) begin
      if (expected_frame_bytes.size() == 0) begin
        error_count++;
        $display("%0t: unexpected frame byte, expected none, actual tx_byte %02h last_byte %0b",
                 $time, tx_ch.tx_byte, tx_ch.last_byte);
      end else begin
        want = expected_frame_bytes.pop_front();
        if (tx_ch.tx_byte !== want.tx_byte) begin
          error_count++;
          $display("%0t: tx_byte mismatch, expected %02h, actual %02h",
                   $time, want.tx_byte, tx_ch.tx_byte);
        end
        if (tx_ch.last_byte !== want.last_byte) begin
          error_count++;
          $display("%0t: last_byte mismatch, expected %0b, actual %0b",
                   $time, want.last_byte, tx_ch.last_byte);
        end
      end
    end
  end

  // Ends the run when no transaction happens for too long.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (tx_ch.valid && tx_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired after %0d idle cycles", $time, idle_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // The byte receiver stalls a random number of cycles before each transaction.
  initial begin
    int stall;
    tx_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        tx_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      tx_ch.ready <= 1'b1;
      do @(posedge clk); while (!tx_ch.valid);
    end
  end

  // Offers one command after a random gap and returns at the edge that accepts it.
  task automatic send_command(input command_t c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.opcode     <= c.opcode;
    cmd_ch.node_id    <= c.node_id;
    cmd_ch.reg_addr   <= c.reg_addr;
    cmd_ch.write_data <= c.write_data;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  task automatic send_fields(input logic op, input logic [6:0] node, input logic [7:0] addr,
                             input logic [15:0] data);
    command_t c;
    c.opcode     = op;
    c.node_id    = node;
    c.reg_addr   = addr;
    c.write_data = data;
    send_command(c);
  endtask

  task automatic send_random_command();
    command_t c;
    c.opcode     = $urandom_range(0, 1) ? cfe_pkg::OP_WRITE : cfe_pkg::OP_READ;
    c.node_id    = 7'($urandom_range(0, 127));
    c.reg_addr   = 8'($urandom_range(0, 255));
    c.write_data = 16'($urandom_range(0, 65535));
    send_command(c);
  endtask

  // Field extremes, both frame kinds, and read commands that carry data to be ignored.
  task automatic test_directed_frames();
    send_fields(cfe_pkg::OP_READ,  7'h00, 8'h00, 16'h0000);
    send_fields(cfe_pkg::OP_WRITE, 7'h00, 8'h00, 16'h0000);
    send_fields(cfe_pkg::OP_READ,  7'h7F, 8'hFF, 16'hFFFF);
    send_fields(cfe_pkg::OP_WRITE, 7'h7F, 8'hFF, 16'hFFFF);
    send_fields(cfe_pkg::OP_READ,  7'h01, 8'h80, 16'h1234);
    send_fields(cfe_pkg::OP_READ,  7'h01, 8'h80, 16'h0000);
    send_fields(cfe_pkg::OP_WRITE, 7'h55, 8'hAA, 16'hA5A5);
    send_fields(cfe_pkg::OP_WRITE, 7'h2A, 8'h55, 16'h5A5A);
    send_fields(cfe_pkg::OP_WRITE, 7'h40, 8'h01, 16'h8000);
    send_fields(cfe_pkg::OP_WRITE, 7'h01, 8'h80, 16'h0001);
    send_fields(cfe_pkg::OP_WRITE, 7'h1E, 8'h1E, 16'h00FF);
    send_fields(cfe_pkg::OP_WRITE, 7'h3C, 8'hC3, 16'hFF00);
    send_fields(cfe_pkg::OP_READ,  7'h1E, 8'h1E, 16'hFFFF);
    send_fields(cfe_pkg::OP_READ,  7'h40, 8'h7F, 16'h8001);
  endtask

  // Random commands with random gaps on both channels.
  task automatic test_random_commands();
    repeat (RANDOM_ITEMS) send_random_command();
  endtask

  // Random commands with both channels always ready, so frames run back to back.
  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (BURST_ITEMS) send_random_command();
    no_idle = 1'b0;
  endtask

  // Stops offering commands and waits until every frame byte has arrived.
  task automatic drain_frames();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_frame_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst               <= 1'b1;
    cmd_ch.valid      <= 1'b0;
    cmd_ch.opcode     <= cfe_pkg::OP_READ;
    cmd_ch.node_id    <= '0;
    cmd_ch.reg_addr   <= '0;
    cmd_ch.write_data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed_frames();
    test_random_commands();
    test_back_to_back();
    test_random_commands();
    drain_frames();

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/cfe_pkg.sv
hdl/cfe_if.sv
hdl/cfe_front.sv
hdl/cfe_queue.sv
hdl/cfe_back.sv
hdl/crc_framed_register_command_encoder_unit.sv
dv/tb_crc_framed_register_command_encoder_unit.sv
